[design/slfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest lossless float encoder package
// Head byte codes, payload lengths and format widths shared by the encoder.
// ----------------------------------------------------------------------------
package slfe_pkg;

  localparam logic [7:0] HEAD_HALF   = 8'hf9;
  localparam logic [7:0] HEAD_SINGLE = 8'hfa;
  localparam logic [7:0] HEAD_DOUBLE = 8'hfb;

  localparam logic [3:0] LEN_HALF   = 4'd2;
  localparam logic [3:0] LEN_SINGLE = 4'd4;
  localparam logic [3:0] LEN_DOUBLE = 4'd8;

  localparam logic [15:0] HALF_NAN  = 16'h7e00;
  localparam logic [15:0] HALF_PINF = 16'h7c00;
  localparam logic [15:0] HALF_NINF = 16'hfc00;
  localparam logic [15:0] HALF_SIGN = 16'h8000;

  // Fraction widths and exponent limits of the three formats.
  localparam int DblFracW    = 52;
  localparam int SglFracW    = 23;
  localparam int HalfFracW   = 10;
  localparam int SglMaxExp   = 254;
  localparam int HalfMaxExp  = 30;
  localparam int DblToSglOff = 1023 - 127;
  localparam int SglToHalfOff = 127 - 15;

  typedef struct packed {
    logic [7:0]  head;
    logic [63:0] payload;
    logic [3:0]  length;
  } slfe_result_t;

endpackage

[design/shortest_lossless_float_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest lossless float encoder core
// Encodes a binary64 value as the shortest exact CBOR float: head byte,
// right-aligned payload and payload length in bytes.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_stall_o | value_bits_i
//   out     | output    | out_valid_o/out_stall_i | head_byte_o, payload_bits_o,
//           |           |                         | payload_length_o
//
// One request per cycle is accepted while in_stall_o is low. A request taken
// is held in the input register, encoded from it, and moves on into the result
// register unless a stall holds that register; its result is offered from there.
// Reset clears both valid flags and needs no clearing pass.
// A stall on the output holds the result register; the input register still
// takes a request while it is empty.
// ----------------------------------------------------------------------------
module shortest_lossless_float_encoder_core import slfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  head_byte_o,
  output logic [63:0] payload_bits_o,
  output logic [3:0]  payload_length_o
);

  logic         s1_valid_q, s1_valid_d;
  logic [63:0]  s1_value_q;
  logic         out_valid_q, out_valid_d;
  slfe_result_t out_res_q;
  slfe_result_t enc_res;
  logic         out_ready;
  logic         s1_ready;

  assign out_ready  = !(out_valid_q && out_stall_i);
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  slfe_encode u_encode (
    .value_bits_i (s1_value_q),
    .result_o     (enc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_value_q <= value_bits_i;
    end
    if (out_ready && s1_valid_q) begin
      out_res_q <= enc_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign head_byte_o      = out_res_q.head;
  assign payload_bits_o   = out_res_q.payload;
  assign payload_length_o = out_res_q.length;

`ifndef SYNTHESIS
  a_len_matches_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (head_byte_o == HEAD_HALF && payload_length_o == LEN_HALF) ||
      (head_byte_o == HEAD_SINGLE && payload_length_o == LEN_SINGLE) ||
      (head_byte_o == HEAD_DOUBLE && payload_length_o == LEN_DOUBLE))
    else $error("payload length does not match head byte");

  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && head_byte_o == HEAD_HALF) |-> (payload_bits_o[63:16] == '0))
    else $error("half payload has bits above 16");

  a_single_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && head_byte_o == HEAD_SINGLE) |-> (payload_bits_o[63:32] == '0))
    else $error("single payload has bits above 32");

  a_request_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted request not held in input register");
`endif

endmodule

[design/slfe_narrow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float narrowing step
// Checks that a significand with its rebiased exponent fits a narrower
// format without losing bits, subnormal results included, and forms it.
// ----------------------------------------------------------------------------
module slfe_narrow import slfe_pkg::*; #(
  parameter int FracW  = SglFracW,
  parameter int DropW  = DblFracW - SglFracW,
  parameter int ExpW   = 12,
  parameter int MaxExp = SglMaxExp
) (
  input  logic signed [ExpW-1:0]             exp_i,
  input  logic        [FracW+DropW-1:0]      frac_i,
  output logic                               ok_o,
  output logic        [$clog2(MaxExp+1)-1:0] exp_o,
  output logic        [FracW-1:0]            frac_o
);

  localparam int EoW     = $clog2(MaxExp + 1);
  localparam int ShW     = $clog2(FracW + 2);
  localparam int MinExpI = -FracW;
  localparam logic signed [ExpW-1:0] MinExp = MinExpI[ExpW-1:0];
  localparam logic signed [ExpW-1:0] MaxExpS = MaxExp[ExpW-1:0];
  localparam logic signed [ExpW-1:0] One = ExpW'(1);

  logic                    in_range;
  logic                    drop_clean;
  logic                    subnormal;
  logic [FracW-1:0]        frac_kept;
  logic [FracW:0]          full;
  logic signed [ExpW-1:0]  sh_full;
  logic [ShW-1:0]          sh;
  logic [FracW:0]          lost_mask;
  logic [FracW:0]          shifted;

  assign in_range   = (exp_i >= MinExp) && (exp_i <= MaxExpS);
  assign drop_clean = (frac_i[DropW-1:0] == '0);
  assign frac_kept  = frac_i[FracW+DropW-1:DropW];
  assign subnormal  = (exp_i < One);

  // A subnormal result shifts the hidden one into the fraction field.
  assign full      = {1'b1, frac_kept};
  assign sh_full   = One - exp_i;
  assign sh        = sh_full[ShW-1:0];
  assign lost_mask = ~({(FracW+1){1'b1}} << sh);
  assign shifted   = full >> sh;

  always_comb begin
    ok_o   = in_range && drop_clean;
    exp_o  = exp_i[EoW-1:0];
    frac_o = frac_kept;
    if (subnormal) begin
      ok_o   = ok_o && ((full & lost_mask) == '0);
      exp_o  = '0;
      frac_o = shifted[FracW-1:0];
    end
  end

endmodule

[design/slfe_encode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest encoding selector
// Maps a binary64 pattern to its shortest exact half, single or double form.
// ----------------------------------------------------------------------------
module slfe_encode import slfe_pkg::*; (
  input  logic [63:0]  value_bits_i,
  output slfe_result_t result_o
);

  localparam int SglEoW  = $clog2(SglMaxExp + 1);
  localparam int HalfEoW = $clog2(HalfMaxExp + 1);

  logic               sign;
  logic [10:0]        dexp;
  logic [51:0]        dfrac;
  logic signed [11:0] e32_in;
  logic               sgl_ok;
  logic [SglEoW-1:0]  e32;
  logic [22:0]        f32;
  logic signed [8:0]  e16_in;
  logic               half_ok;
  logic [HalfEoW-1:0] e16;
  logic [9:0]         f16;

  assign sign  = value_bits_i[63];
  assign dexp  = value_bits_i[62:52];
  assign dfrac = value_bits_i[51:0];

  assign e32_in = $signed({1'b0, dexp}) - 12'sd896;

  slfe_narrow #(
    .FracW  (SglFracW),
    .DropW  (DblFracW - SglFracW),
    .ExpW   (12),
    .MaxExp (SglMaxExp)
  ) u_to_single (
    .exp_i  (e32_in),
    .frac_i (dfrac),
    .ok_o   (sgl_ok),
    .exp_o  (e32),
    .frac_o (f32)
  );

  assign e16_in = $signed({1'b0, e32}) - 9'sd112;

  slfe_narrow #(
    .FracW  (HalfFracW),
    .DropW  (SglFracW - HalfFracW),
    .ExpW   (9),
    .MaxExp (HalfMaxExp)
  ) u_to_half (
    .exp_i  (e16_in),
    .frac_i (f32),
    .ok_o   (half_ok),
    .exp_o  (e16),
    .frac_o (f16)
  );

  always_comb begin
    result_o.head    = HEAD_DOUBLE;
    result_o.length  = LEN_DOUBLE;
    result_o.payload = value_bits_i;
    if (value_bits_i[62:0] == '0) begin
      result_o.head    = HEAD_HALF;
      result_o.length  = LEN_HALF;
      result_o.payload = {48'd0, (sign ? HALF_SIGN : 16'd0)};
    end else if (dexp == '1) begin
      // Every NaN collapses to the one quiet half NaN.
      result_o.head   = HEAD_HALF;
      result_o.length = LEN_HALF;
      if (dfrac != '0) begin
        result_o.payload = {48'd0, HALF_NAN};
      end else begin
        result_o.payload = {48'd0, (sign ? HALF_NINF : HALF_PINF)};
      end
    end else if (sgl_ok && half_ok) begin
      result_o.head    = HEAD_HALF;
      result_o.length  = LEN_HALF;
      result_o.payload = {48'd0, sign, e16, f16};
    end else if (sgl_ok) begin
      result_o.head    = HEAD_SINGLE;
      result_o.length  = LEN_SINGLE;
      result_o.payload = {32'd0, sign, e32, f32};
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest lossless float encoder testbench
// Sends binary64 bit patterns through the encoder under random gaps and
// output stalls, predicts each head byte, payload and length in the bench or
// takes it typed in, and compares every result in order against the expectations.
// ----------------------------------------------------------------------------
module testbench;
  import slfe_pkg::*;

  typedef struct {
    logic [63:0]  value;
    bit           typed;
    slfe_result_t want;
  } stim_row_t;

  localparam int RandomRequests = 1800;
  localparam int PressureAt     = 60;
  localparam int PressureCycles = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] value_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  head_byte_o;
  logic [63:0] payload_bits_o;
  logic [3:0]  payload_length_o;

  slfe_result_t pending_encodings[$];
  int           mismatch_count = 0;
  int           results_seen = 0;

  // Zeros, infinities, NaNs, one and the plain extremes have their results typed
  // in; the narrowing boundaries are left to the predictor.
  stim_row_t directed_rows [24] = '{
    '{64'h0000000000000000, 1'b1, '{HEAD_HALF, 64'h0000, LEN_HALF}},
    '{64'h8000000000000000, 1'b1, '{HEAD_HALF, 64'h8000, LEN_HALF}},
    '{64'h7ff0000000000000, 1'b1, '{HEAD_HALF, 64'h7c00, LEN_HALF}},
    '{64'hfff0000000000000, 1'b1, '{HEAD_HALF, 64'hfc00, LEN_HALF}},
    '{64'h7ff8000000000000, 1'b1, '{HEAD_HALF, 64'h7e00, LEN_HALF}},
    '{64'h7ff0000000000001, 1'b1, '{HEAD_HALF, 64'h7e00, LEN_HALF}},
    '{64'hffffffffffffffff, 1'b1, '{HEAD_HALF, 64'h7e00, LEN_HALF}},
    '{64'h3ff0000000000000, 1'b1, '{HEAD_HALF, 64'h3c00, LEN_HALF}},
    '{64'h0000000000000001, 1'b1, '{HEAD_DOUBLE, 64'h0000000000000001, LEN_DOUBLE}},
    '{64'h7fefffffffffffff, 1'b1, '{HEAD_DOUBLE, 64'h7fefffffffffffff, LEN_DOUBLE}},
    '{64'h40effc0000000000, 1'b0, '0},
    '{64'hc0effc0000000000, 1'b0, '0},
    '{64'h40f0000000000000, 1'b0, '0},
    '{64'h3e70000000000000, 1'b0, '0},
    '{64'h3f10000000000000, 1'b0, '0},
    '{64'h3e78000000000000, 1'b0, '0},
    '{64'h36a0000000000000, 1'b0, '0},
    '{64'h3690000000000000, 1'b0, '0},
    '{64'h47efffffe0000000, 1'b0, '0},
    '{64'h47f0000000000000, 1'b0, '0},
    '{64'h3ff0000000000001, 1'b0, '0},
    '{64'h3fb999999999999a, 1'b0, '0},
    '{64'h3ff0000020000000, 1'b0, '0},
    '{64'h3ff0000010000000, 1'b0, '0}
  };

  shortest_lossless_float_encoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_bits_i    (value_bits_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .head_byte_o     (head_byte_o),
    .payload_bits_o  (payload_bits_o),
    .payload_length_o(payload_length_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Moves a fraction into a narrower format. Fails when a set bit would be
  // shifted out, also while the result is made subnormal, or when the
  // exponent is out of range.
  function automatic bit narrow_fraction(input int exp_in, input logic [63:0] frac_in,
                                         input int frac_w, input int drop_w,
                                         input int max_exp, output int exp_out,
                                         output logic [63:0] frac_out);
    logic [63:0] f;
    logic [63:0] full;
    int          e;
    int          sh;
    e        = exp_in;
    f        = frac_in;
    exp_out  = 0;
    frac_out = '0;
    if (e < -frac_w || e > max_exp) return 1'b0;
    if ((f & ((64'd1 << drop_w) - 64'd1)) != 64'd0) return 1'b0;
    f = f >> drop_w;
    if (e <= 0) begin
      sh   = 1 - e;
      full = f + (64'd1 << frac_w);
      f    = full >> sh;
      if ((f << sh) != full) return 1'b0;
      e = 0;
    end
    exp_out  = e;
    frac_out = f;
    return 1'b1;
  endfunction

  function automatic slfe_result_t encode_shortest(input logic [63:0] v);
    slfe_result_t r;
    int           e_sgl;
    int           e_half;
    int           e_dbl;
    logic [63:0]  f_sgl;
    logic [63:0]  f_half;
    logic [31:0]  sgl_bits;
    r.head   = HEAD_HALF;
    r.length = LEN_HALF;
    if (v[62:0] == 63'd0) begin
      r.payload = {48'd0, v[63] ? HALF_SIGN : 16'h0000};
      return r;
    end
    if (v[62:52] == 11'h7ff) begin
      if (v[51:0] != 52'd0) r.payload = {48'd0, HALF_NAN};
      else r.payload = {48'd0, v[63] ? HALF_NINF : HALF_PINF};
      return r;
    end
    e_dbl = int'(v[62:52]);
    if (!narrow_fraction(e_dbl - DblToSglOff, {12'd0, v[51:0]}, SglFracW,
                         DblFracW - SglFracW, SglMaxExp, e_sgl, f_sgl)) begin
      r.head    = HEAD_DOUBLE;
      r.length  = LEN_DOUBLE;
      r.payload = v;
      return r;
    end
    sgl_bits = {v[63], e_sgl[7:0], f_sgl[22:0]};
    if (!narrow_fraction(e_sgl - SglToHalfOff, f_sgl, HalfFracW,
                         SglFracW - HalfFracW, HalfMaxExp, e_half, f_half)) begin
      r.head    = HEAD_SINGLE;
      r.length  = LEN_SINGLE;
      r.payload = {32'd0, sgl_bits};
      return r;
    end
    r.payload = {48'd0, sgl_bits[31], e_half[4:0], f_half[9:0]};
    return r;
  endfunction

  // Most patterns keep only a few leading fraction bits and an exponent near
  // the half or single range, so that both narrowing steps are exercised;
  // the rest are raw noise, specials and subnormals, some with one stray bit.
  function automatic logic [63:0] draw_float_pattern();
    logic [63:0] v;
    logic [51:0] frac;
    logic [10:0] ex;
    int          kind;
    int          keep;
    kind = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if (kind < 15) return v;
    keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 52) : $urandom_range(0, 24);
    frac = v[51:0];
    if (keep == 0) frac = '0;
    else frac = frac & ~((52'd1 << (52 - keep)) - 52'd1);
    if (kind < 55) ex = 11'($urandom_range(1023 - 26, 1023 + 16));
    else if (kind < 85) ex = 11'($urandom_range(1023 - 151, 1023 + 128));
    else if (kind < 92) ex = ($urandom_range(0, 1) == 1) ? 11'h7ff : 11'h000;
    else ex = 11'($urandom_range(0, 2047));
    v = {v[63], ex, frac};
    if (kind >= 85 && kind < 92 && $urandom_range(0, 1) == 1) v[51:0] = '0;
    if ($urandom_range(0, 9) == 0) v = v ^ (64'd1 << $urandom_range(0, 51));
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [63:0] v, input slfe_result_t want,
                              input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_bits_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_encodings.push_back(want);
    @(negedge clk_i);
  endtask

  // Result side: draws a stall length per result, with one long hold-off so
  // that the pipeline fills and pushes back on the request side.
  initial begin
    slfe_result_t want;
    int           hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_seen == PressureAt) hold = PressureCycles;
      else if ((results_seen / 130) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
      if (pending_encodings.size() == 0) begin
        report_mismatch("result with no request outstanding", payload_bits_o, '0);
      end else begin
        want = pending_encodings.pop_front();
        if (head_byte_o !== want.head)
          report_mismatch("head byte", {56'd0, head_byte_o}, {56'd0, want.head});
        if (payload_bits_o !== want.payload)
          report_mismatch("payload", payload_bits_o, want.payload);
        if (payload_length_o !== want.length)
          report_mismatch("length", {60'd0, payload_length_o}, {60'd0, want.length});
      end
      @(negedge clk_i);
    end
  end

  initial begin
    logic [63:0] v;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    value_bits_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].value,
                   directed_rows[i].typed ? directed_rows[i].want
                                          : encode_shortest(directed_rows[i].value),
                   1'b0);
    end
    for (int n = 0; n < RandomRequests; n++) begin
      v = draw_float_pattern();
      send_request(v, encode_shortest(v), (n / 150) % 3 == 2);
    end
    in_valid_i <= 1'b0;
    while (pending_encodings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("shortest_lossless_float_encoder_core: match");
    end else begin
      $display("shortest_lossless_float_encoder_core: mismatch");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("shortest_lossless_float_encoder_core: mismatch");
    $finish;
  end

endmodule
